### src/eslc_pkg.sv
`timescale 1ns / 1ps
package eslc_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] DELIM_RST = 8'd34;
  localparam logic [15:0] MAX_LEN_RST = 16'd255;
  localparam logic [7:0] CTRL_MASK = 8'd31;

  typedef enum logic [2:0] {
    M_NORMAL,
    M_ESCAPE,
    M_HEX1,
    M_HEX2,
    M_OCT
  } mode_t;

  typedef enum logic [1:0] {
    K_DATA,
    K_END,
    K_ERR
  } kind_t;

  typedef enum logic {
    REG_DELIM,
    REG_MAX_LEN
  } reg_idx_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] len;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pkt_t;

  typedef struct packed {
    logic [3:0] val;
    logic       ok;
  } hex_t;

  function automatic hex_t hex_val(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.val = 4'd0;
    if (b >= "0" && b <= "9") begin
      h.val = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      h.val = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      h.val = 4'(b - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

endpackage

### src/eslc_front.sv
`timescale 1ns / 1ps
module eslc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              op,
  input  logic [7:0]        src_byte,
  input  logic [7:0]        delimiter,
  input  logic [15:0]       max_len,
  output logic              push,
  output eslc_pkg::pkt_t    push_pkt
);
  import eslc_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [7:0]  acc;
    logic [1:0]  dig;
    logic [15:0] cnt;
    logic        disc;
    logic [1:0]  n;
    res_t        r0;
    res_t        r1;
  } work_t;

  mode_t       mode;
  mode_t       mode_next;
  logic [7:0]  acc;
  logic [7:0]  acc_next;
  logic [1:0]  dig;
  logic [1:0]  dig_next;
  logic [15:0] cnt;
  logic [15:0] cnt_next;
  logic        disc;
  logic        disc_next;
  work_t       w;

  function automatic work_t f_put(input work_t s, input kind_t k, input logic [7:0] b,
                                  input logic [15:0] len);
    work_t t;
    res_t r;
    t = s;
    r.kind = k;
    r.data = b;
    r.len = len;
    if (t.n == 2'd0) begin
      t.r0 = r;
      t.n = 2'd1;
    end else if (t.n == 2'd1) begin
      t.r1 = r;
      t.n = 2'd2;
    end
    return t;
  endfunction

  function automatic work_t f_clear(input work_t s);
    work_t t;
    t = s;
    t.mode = M_NORMAL;
    t.acc = 8'd0;
    t.dig = 2'd0;
    t.cnt = 16'd0;
    t.disc = 1'b0;
    return t;
  endfunction

  function automatic work_t f_finish(input work_t s);
    return f_clear(f_put(s, K_END, 8'd0, s.cnt));
  endfunction

  function automatic work_t f_fail(input work_t s);
    return f_clear(f_put(s, K_ERR, 8'd0, 16'd0));
  endfunction

  function automatic work_t f_emit(input work_t s, input logic [7:0] b,
                                   input logic [15:0] maxl);
    work_t t;
    t = s;
    if (t.disc || t.cnt >= maxl) begin
      t.disc = 1'b1;
      t.mode = M_NORMAL;
    end else begin
      t = f_put(t, K_DATA, b, 16'd0);
      t.cnt = t.cnt + 16'd1;
    end
    return t;
  endfunction

  function automatic work_t f_normal(input work_t s, input logic [7:0] b,
                                     input logic [7:0] dl, input logic [15:0] maxl);
    work_t t;
    t = s;
    if (b == dl) begin
      t = f_finish(t);
    end else if (t.disc || t.cnt >= maxl) begin
      t.disc = 1'b1;
    end else if (b == "\\") begin
      t.mode = M_ESCAPE;
    end else begin
      t = f_emit(t, b, maxl);
    end
    return t;
  endfunction

  function automatic work_t f_escape(input work_t s, input logic [7:0] b,
                                     input logic [15:0] maxl);
    work_t t;
    t = s;
    t.mode = M_NORMAL;
    case (b)
      "z": t = f_emit(t, 8'd0, maxl);
      "t": t = f_emit(t, 8'd9, maxl);
      "n": t = f_emit(t, 8'd10, maxl);
      "l": t = f_emit(t, 8'd10, maxl);
      "r": t = f_emit(t, 8'd13, maxl);
      "m": t = f_emit(f_emit(t, 8'd13, maxl), 8'd10, maxl);
      "b": t = f_emit(t, 8'd8, maxl);
      "a": t = f_emit(t, 8'd7, maxl);
      "f": t = f_emit(t, 8'd12, maxl);
      "v": t = f_emit(t, 8'd11, maxl);
      "e": t = f_emit(t, 8'd27, maxl);
      "i": t = f_emit(t, 8'd39, maxl);
      "q": t = f_emit(t, 8'd34, maxl);
      "x": t.mode = M_HEX1;
      default: begin
        if (b >= "0" && b <= "7") begin
          t.mode = M_OCT;
          t.acc = {5'd0, b[2:0]};
          t.dig = 2'd1;
        end else if (b >= "A" && b <= "Z") begin
          t = f_emit(t, b & CTRL_MASK, maxl);
        end else if (!is_alnum(b)) begin
          t = f_emit(t, b, maxl);
        end else begin
          t = f_fail(t);
        end
      end
    endcase
    return t;
  endfunction

  always_comb begin
    hex_t       hv;
    logic [7:0] a_old;
    logic [7:0] a_new;
    w = '0;
    w.mode = mode;
    w.acc = acc;
    w.dig = dig;
    w.cnt = cnt;
    w.disc = disc;
    a_old = acc;
    a_new = {acc[4:0], src_byte[2:0]};
    hv = hex_val(src_byte);
    if (op) begin
      case (mode)
        M_HEX1: w = f_fail(w);
        M_HEX2, M_OCT: begin
          w.mode = M_NORMAL;
          w = f_finish(f_emit(w, a_old, max_len));
        end
        default: w = f_finish(w);
      endcase
    end else begin
      case (mode)
        M_ESCAPE: w = f_escape(w, src_byte, max_len);
        M_HEX1: begin
          if (!hv.ok) begin
            w = f_fail(w);
          end else begin
            w.acc = {4'd0, hv.val};
            w.mode = M_HEX2;
          end
        end
        M_HEX2: begin
          w.mode = M_NORMAL;
          w.acc = 8'd0;
          if (hv.ok) begin
            w = f_emit(w, {a_old[3:0], hv.val}, max_len);
          end else begin
            w = f_normal(f_emit(w, a_old, max_len), src_byte, delimiter, max_len);
          end
        end
        M_OCT: begin
          if (src_byte >= "0" && src_byte <= "7") begin
            w.acc = a_new;
            w.dig = dig + 2'd1;
            if (w.dig == 2'd3) begin
              w.mode = M_NORMAL;
              w.acc = 8'd0;
              w.dig = 2'd0;
              w = f_emit(w, a_new, max_len);
            end
          end else begin
            w.mode = M_NORMAL;
            w.acc = 8'd0;
            w.dig = 2'd0;
            w = f_normal(f_emit(w, a_old, max_len), src_byte, delimiter, max_len);
          end
        end
        default: begin
          w.mode = M_NORMAL;
          w = f_normal(w, src_byte, delimiter, max_len);
        end
      endcase
    end
  end

  always_comb begin
    mode_next = mode;
    acc_next = acc;
    dig_next = dig;
    cnt_next = cnt;
    disc_next = disc;
    if (accept) begin
      mode_next = w.mode;
      acc_next = w.acc;
      dig_next = w.dig;
      cnt_next = w.cnt;
      disc_next = w.disc;
    end
  end

  always_comb begin
    push = accept && (w.n != 2'd0);
    push_pkt.two = (w.n == 2'd2);
    push_pkt.r0 = w.r0;
    push_pkt.r1 = w.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_NORMAL;
      acc <= 8'd0;
      dig <= 2'd0;
      cnt <= 16'd0;
      disc <= 1'b0;
    end else begin
      mode <= mode_next;
      acc <= acc_next;
      dig <= dig_next;
      cnt <= cnt_next;
      disc <= disc_next;
    end
  end

endmodule

### src/eslc_queue.sv
`timescale 1ns / 1ps
module eslc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  eslc_pkg::pkt_t  push_pkt,
  input  logic            pop,
  output logic            ready,
  output logic            head_valid,
  output eslc_pkg::pkt_t  head
);
  import eslc_pkg::*;

  pkt_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign ready = (count != QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/eslc_back.sv
`timescale 1ns / 1ps
module eslc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  eslc_pkg::pkt_t  head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [15:0]     out_length,
  output logic            last
);
  import eslc_pkg::*;

  logic sel;
  logic load;
  logic final_res;
  res_t cur;

  assign load = head_valid && (!out_valid || out_ready);
  assign cur = sel ? head.r1 : head.r0;
  assign final_res = sel || !head.two;
  assign pop = load && final_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        sel <= !final_res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= cur.kind;
      out_byte <= cur.data;
      out_length <= cur.len;
      last <= final_res;
    end
  end

endmodule

### src/escaped_string_literal_decoder.sv
// Escaped string literal decoder.
// Input channel (in_valid/in_ready, op, src_byte): one source byte per
// transfer, or an end-of-line marker when op is 1. Output channel
// (out_valid/out_ready, kind, out_byte, out_length, last): zero, one or two
// results per input transfer, in order; last marks the final one of a transfer.
// The first result of a transfer is registered in the queue and then in the
// output register before the receiver can take it.
// Throughput: one input transfer per cycle while each transfer gives at most
// one result and the receiver does not stall; a transfer giving two results
// occupies the single output register longer, as it drains one result per cycle.
// A two-entry queue between the decoder and the output stage absorbs that,
// and in_ready drops only when the queue is full.
// When the receiver stalls, the output holds its result and the queue fills;
// then in_ready falls until the receiver takes data again.
// Reset (rst, synchronous) returns to normal text with a zero count, empties
// the queue and loads delimiter 34 and max_len 255.
// Registers on the APB port: delimiter at byte address 0, max_len at 4.
// Write them only while the block is idle.
`timescale 1ns / 1ps
module escaped_string_literal_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  src_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [15:0] out_length,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import eslc_pkg::*;

  logic [7:0]  delimiter;
  logic [15:0] max_len;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  logic        accept;
  logic        push;
  pkt_t        push_pkt;
  logic        q_ready;
  logic        head_valid;
  pkt_t        head;
  logic        pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RST;
      max_len <= MAX_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DELIM: delimiter <= pwdata[7:0];
        REG_MAX_LEN: max_len <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DELIM: prdata = {24'd0, delimiter};
      REG_MAX_LEN: prdata = {16'd0, max_len};
      default: prdata = 32'd0;
    endcase
  end

  assign in_ready = q_ready;
  assign accept = in_valid && in_ready;

  eslc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .op        (op),
    .src_byte  (src_byte),
    .delimiter (delimiter),
    .max_len   (max_len),
    .push      (push),
    .push_pkt  (push_pkt)
  );

  eslc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_pkt   (push_pkt),
    .pop        (pop),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head       (head)
  );

  eslc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .out_byte   (out_byte),
    .out_length (out_length),
    .last       (last)
  );

endmodule
